// ===== rtl/core/lrucc_pkg.sv =====
package lrucc_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 64;
  localparam int DATA_BITS = 32;

  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam int CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam int STAT_BITS = 3;

  localparam int IN_TDATA_BITS  = ((KEY_BITS + DATA_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((DATA_BITS + KEY_BITS + 7) / 8) * 8;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_CAPACITY = 1'b0;   // word index of the capacity register

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ADD    = 1'b1;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_MISS     = 3'd0,
    STAT_HIT      = 3'd1,
    STAT_UPDATED  = 3'd2,
    STAT_INSERTED = 3'd3,
    STAT_EVICTED  = 3'd4,
    STAT_REJECTED = 3'd5
  } lrucc_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COMMIT
  } lrucc_state_t;

  typedef struct packed {
    logic load;     // capture the incoming item
    logic look;     // search the store, register match and victim
    logic commit;   // update the store and load the result register
  } lrucc_cmd_t;

  typedef struct packed {
    logic out_free; // result register empty or being drained this cycle
  } lrucc_sts_t;

endpackage

// ===== rtl/core/lrucc_ctrl.sv =====
module lrucc_ctrl import lrucc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  lrucc_sts_t sts,
  output lrucc_cmd_t cmd
);

  lrucc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the previous result has left the output register
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lrucc_datapath.sv =====
module lrucc_datapath import lrucc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrucc_cmd_t           cmd,
  output lrucc_sts_t           sts,
  input  logic                 in_req_type,
  input  logic [KEY_BITS-1:0]  in_key,
  input  logic [DATA_BITS-1:0] in_data,
  input  logic [CAP_BITS-1:0]  cap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_BITS-1:0] out_status,
  output logic [DATA_BITS-1:0] out_data,
  output logic [KEY_BITS-1:0]  out_evkey
);

  // captured request
  logic                 req_type_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;

  // entry storage
  logic [KEY_BITS-1:0]  key_store  [DEPTH];
  logic [DATA_BITS-1:0] data_store [DEPTH];
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [RANK_BITS-1:0] rank_r   [DEPTH];
  logic [RANK_BITS-1:0] rank_nxt [DEPTH];
  logic [CNT_BITS-1:0]  occ_r, occ_nxt;

  // lookup stage results
  logic                 hit_r;
  logic [IDX_BITS-1:0]  hit_idx_r;
  logic [RANK_BITS-1:0] hit_rank_r;
  logic [DATA_BITS-1:0] hit_data_r;
  logic [IDX_BITS-1:0]  lru_idx_r;
  logic [KEY_BITS-1:0]  lru_key_r;
  logic [IDX_BITS-1:0]  free_idx_r;
  logic                 full_r;
  logic                 cap_zero_r;

  // result register
  logic                 out_valid_r;
  logic [STAT_BITS-1:0] status_r, status_nxt;
  logic [DATA_BITS-1:0] dout_r, dout_nxt;
  logic [KEY_BITS-1:0]  ekey_r, ekey_nxt;

  logic                 hit_c;
  logic [IDX_BITS-1:0]  hit_idx_c, lru_idx_c, free_idx_c;
  logic [CMP_BITS-1:0]  cap_eff_c;
  logic [RANK_BITS-1:0] lru_rank_c;

  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_idx;
  logic                 wr_key_en;

  // parallel search: key match, least recent entry, first free slot
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    lru_idx_c  = '0;
    free_idx_c = '0;
    lru_rank_c = RANK_BITS'(occ_r - CNT_BITS'(1));
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && key_store[i] == key_r) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_BITS'(i);
      end
      if (valid_r[i] && rank_r[i] == lru_rank_c) begin
        lru_idx_c = IDX_BITS'(i);
      end
      if (!valid_r[i]) begin
        free_idx_c = IDX_BITS'(i);
      end
    end
  end

  // clamp capacity to the store depth
  always_comb begin
    if (CMP_BITS'(cap) > CMP_BITS'(DEPTH)) begin
      cap_eff_c = CMP_BITS'(DEPTH);
    end else begin
      cap_eff_c = CMP_BITS'(cap);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      key_r      <= in_key;
      data_r     <= in_data;
    end
    if (cmd.look) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      hit_rank_r <= rank_r[hit_idx_c];
      hit_data_r <= data_store[hit_idx_c];
      lru_idx_r  <= lru_idx_c;
      lru_key_r  <= key_store[lru_idx_c];
      free_idx_r <= free_idx_c;
      full_r     <= CMP_BITS'(occ_r) >= cap_eff_c;
      cap_zero_r <= cap_eff_c == '0;
    end
  end

  // commit: decide the outcome and the new recency order
  always_comb begin
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    occ_nxt    = occ_r;
    status_nxt = STAT_MISS;
    dout_nxt   = '0;
    ekey_nxt   = '0;
    wr_en      = 1'b0;
    wr_key_en  = 1'b0;
    wr_idx     = hit_idx_r;
    if (req_type_r == REQ_LOOKUP || (!cap_zero_r && hit_r)) begin
      if (hit_r) begin
        if (req_type_r == REQ_LOOKUP) begin
          status_nxt = STAT_HIT;
          dout_nxt   = hit_data_r;
        end else begin
          status_nxt = STAT_UPDATED;
          wr_en      = 1'b1;
        end
        // age entries more recent than the touched one
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i] && rank_r[i] < hit_rank_r) begin
            rank_nxt[i] = rank_r[i] + RANK_BITS'(1);
          end
          if (IDX_BITS'(i) == hit_idx_r) begin
            rank_nxt[i] = '0;
          end
        end
      end
    end else if (cap_zero_r) begin
      status_nxt = STAT_REJECTED;
    end else begin
      wr_en     = 1'b1;
      wr_key_en = 1'b1;
      if (full_r) begin
        status_nxt = STAT_EVICTED;
        ekey_nxt   = lru_key_r;
        wr_idx     = lru_idx_r;
      end else begin
        status_nxt = STAT_INSERTED;
        wr_idx     = free_idx_r;
        occ_nxt    = occ_r + CNT_BITS'(1);
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_r[i] && IDX_BITS'(i) != wr_idx) begin
          rank_nxt[i] = rank_r[i] + RANK_BITS'(1);
        end
        if (IDX_BITS'(i) == wr_idx) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      data_store[wr_idx] <= data_r;
      if (wr_key_en) begin
        key_store[wr_idx] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      dout_r   <= dout_nxt;
      ekey_r   <= ekey_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_data     = dout_r;
  assign out_evkey    = ekey_r;

endmodule

// ===== rtl/core/lru_content_cache.sv =====
// Fully associative content store of DEPTH entries with least-recently-used
// replacement. Each input item is a lookup (tuser 0) or an add (tuser 1) of a
// name key with a data handle; each one yields exactly one result item with a
// status (miss, hit, updated, inserted, inserted with eviction, rejected), the
// stored handle on a lookup hit and the evicted key on an eviction. Items are
// handled one at a time: each is accepted, then its key is searched over all
// entries at once, then the store and recency order are committed, and the
// commit waits while the output register holds a result not being drained.
// The next item is accepted while a result still waits downstream.
// Capacity (register 0, byte address 0, reset 16) is clamped to the depth;
// zero rejects every add while lookups still search. Stores need no clearing
// pass after reset: entries become visible only through their valid marks.
module lru_content_cache import lrucc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // name_key, data_handle
  input  logic                      in_tuser,   // req_type
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // data_out, evicted_key
  output logic [STAT_BITS-1:0]      out_tuser,  // status
  // configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [APB_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [APB_DATA_BITS-1:0]  cfg_prdata,
  output logic                      cfg_pready
);

  logic [CAP_BITS-1:0]  cap_r;
  logic                 cap_sel;
  lrucc_cmd_t           cmd;
  lrucc_sts_t           sts;
  logic [DATA_BITS-1:0] dout;
  logic [KEY_BITS-1:0]  ekey;

  // Register decode ignores the byte offset within the word.
  assign cap_sel    = cfg_paddr[2] == REG_CAPACITY;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cap_sel) begin
      cap_r <= cfg_pwdata[CAP_BITS-1:0];
    end
  end

  assign cfg_prdata = cap_sel ? APB_DATA_BITS'(cap_r) : '0;

  // Sequence each item: accept, search, commit.
  lrucc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry storage, recency ranks and the result register.
  lrucc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_tuser),
    .in_key      (in_tdata[KEY_BITS-1:0]),
    .in_data     (in_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS]),
    .cap         (cap_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_data    (dout),
    .out_evkey   (ekey)
  );

  // Pack the result, handle in the low bits, evicted key above it.
  assign out_tdata = OUT_TDATA_BITS'({ekey, dout});

endmodule

// ===== sim/lru_content_cache_tb.sv =====
`timescale 1ns / 100ps

module lru_content_cache_tb;
  import lrucc_pkg::*;

  // Byte address of the capacity register: word index times four.
  localparam logic [APB_ADDR_BITS-1:0] CAP_ADDR = APB_ADDR_BITS'({REG_CAPACITY, 2'b00});
  localparam int KEY_POOL = 20;          // keys reused so that hits and updates happen
  localparam int PHASES = 8;
  localparam int RAND_PER_PHASE = 225;
  localparam int STALL_LIMIT = 5000;     // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic                 req;     // REQ_LOOKUP or REQ_ADD
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] handle;
  } cache_req_t;

  typedef struct {
    lrucc_status_t        status;
    logic [DATA_BITS-1:0] data;
    logic [KEY_BITS-1:0]  victim;
  } cache_reply_t;

  logic clk;
  logic rst_n;

  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // name_key, data_handle
  logic                      in_tuser;   // req_type
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // data_out, evicted_key
  logic [STAT_BITS-1:0]      out_tuser;  // status
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [APB_ADDR_BITS-1:0]  cfg_paddr;
  logic [APB_DATA_BITS-1:0]  cfg_pwdata;
  logic [APB_DATA_BITS-1:0]  cfg_prdata;
  logic                      cfg_pready;

  lru_content_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the store: keys, handles, valid marks, recency ranks
  // (0 = most recent), occupancy and the capacity register.
  // ---------------------------------------------------------------------------
  logic [KEY_BITS-1:0]  shadow_key    [DEPTH];
  logic [DATA_BITS-1:0] shadow_handle [DEPTH];
  logic                 shadow_live   [DEPTH];
  logic [RANK_BITS-1:0] shadow_rank   [DEPTH];
  int unsigned          shadow_fill;
  logic [CAP_BITS-1:0]  shadow_cap;

  cache_req_t   pending_reqs[$];       // items waiting for the driver
  cache_reply_t predicted_replies[$];  // replies owed by the block, oldest first

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned reqs_accepted;
  int unsigned replies_seen;
  int unsigned status_tally[6];
  int unsigned quiet_cycles;

  logic [KEY_BITS-1:0] key_pool[KEY_POOL];
  logic [KEY_BITS-1:0] last_key;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Mark slot s as the most recent; entries more recent than it age by one.
  function automatic void promote_slot(input int s);
    logic [RANK_BITS-1:0] old_rank;
    old_rank = shadow_rank[s];
    for (int i = 0; i < DEPTH; i++)
      if (shadow_live[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
    shadow_rank[s] = '0;
  endfunction

  // Apply one request to the shadow store and return the reply it must cause.
  function automatic cache_reply_t cache_predict(input cache_req_t rq);
    cache_reply_t rp;
    int hit_slot;
    int slot;
    int unsigned lim;
    hit_slot = -1;
    slot = -1;
    rp.status = STAT_MISS;
    rp.data = '0;
    rp.victim = '0;
    lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    for (int i = 0; i < DEPTH; i++)
      if (hit_slot < 0 && shadow_live[i] && shadow_key[i] == rq.key) hit_slot = i;

    if (rq.req == REQ_LOOKUP) begin
      if (hit_slot >= 0) begin
        rp.status = STAT_HIT;
        rp.data = shadow_handle[hit_slot];
        promote_slot(hit_slot);
      end
    end else if (lim == 0) begin
      rp.status = STAT_REJECTED;
    end else if (hit_slot >= 0) begin
      rp.status = STAT_UPDATED;
      shadow_handle[hit_slot] = rq.handle;
      promote_slot(hit_slot);
    end else begin
      rp.status = STAT_INSERTED;
      // At or above capacity: drop the least recent entry and reuse its slot.
      if (shadow_fill >= lim) begin
        for (int i = 0; i < DEPTH; i++)
          if (shadow_live[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot])) slot = i;
        rp.status = STAT_EVICTED;
        rp.victim = shadow_key[slot];
        shadow_live[slot] = 1'b0;
        shadow_fill--;
      end else begin
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && !shadow_live[i]) slot = i;
      end
      for (int i = 0; i < DEPTH; i++)
        if (shadow_live[i]) shadow_rank[i]++;
      shadow_key[slot] = rq.key;
      shadow_handle[slot] = rq.handle;
      shadow_live[slot] = 1'b1;
      shadow_rank[slot] = '0;
      shadow_fill++;
    end
    return rp;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold an item until it is taken, then advance or idle at random.
  // The prediction runs on the item accepted at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    cache_req_t nxt;
    cache_req_t took;
    cache_reply_t rp;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        took.req = in_tuser;
        took.key = in_tdata[KEY_BITS-1:0];
        took.handle = in_tdata[KEY_BITS +: DATA_BITS];
        rp = cache_predict(took);
        predicted_replies = {predicted_replies, rp};
        status_tally[rp.status]++;
        reqs_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.req;
          in_tdata <= {nxt.handle, nxt.key};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each reply with the oldest prediction, stall at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : reply_monitor
    cache_reply_t want;
    lrucc_status_t got_status;
    logic [DATA_BITS-1:0] got_data;
    logic [KEY_BITS-1:0] got_victim;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        replies_seen++;
        got_status = lrucc_status_t'(out_tuser);
        got_data = out_tdata[DATA_BITS-1:0];
        got_victim = out_tdata[DATA_BITS +: KEY_BITS];
        if (predicted_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with nothing predicted", replies_seen));
        end else begin
          want = predicted_replies.pop_front();
          if (got_status !== want.status)
            report_mismatch($sformatf("reply %0d status %0d, predicted %s",
                                      replies_seen, out_tuser, want.status.name()));
          if (got_data !== want.data)
            report_mismatch($sformatf("reply %0d data %h, predicted %h",
                                      replies_seen, got_data, want.data));
          if (got_victim !== want.victim)
            report_mismatch($sformatf("reply %0d evicted key %h, predicted %h",
                                      replies_seen, got_victim, want.victim));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [KEY_BITS-1:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_req(input logic req, input logic [KEY_BITS-1:0] key,
                           input logic [DATA_BITS-1:0] handle);
    cache_req_t rq;
    rq.req = req;
    rq.key = key;
    rq.handle = handle;
    pending_reqs = {pending_reqs, rq};
    last_key = key;
  endtask

  // Mostly keys from the pool, some repeats of the previous key, some fresh ones.
  task automatic queue_random_req();
    int unsigned pick;
    logic [KEY_BITS-1:0] key;
    pick = $urandom_range(99);
    if (pick < 72) key = key_pool[$urandom_range(KEY_POOL - 1)];
    else if (pick < 84) key = last_key;
    else key = random_key();
    queue_req($urandom_range(1) ? REQ_ADD : REQ_LOOKUP, key, $urandom());
  endtask

  // Hold until the sender has nothing left and every reply has come back.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || predicted_replies.size() > 0)
      @(posedge clk);
  endtask

  // Write the capacity register, then read it back.
  task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CAP_ADDR;
    cfg_pwdata <= APB_DATA_BITS'(cap);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    shadow_cap = cap;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[CAP_BITS-1:0] !== cap)
      report_mismatch($sformatf("capacity reads back %0d after writing %0d",
                                cfg_prdata[CAP_BITS-1:0], cap));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence: one capacity setting per phase, each with its own idling.
  // The order walks the full store, a setting above the depth, a drop below
  // the occupancy, rejection at zero, tiny stores and a regrowth.
  // ---------------------------------------------------------------------------
  int unsigned phase_cap[PHASES] = '{16, 31, 3, 0, 1, 2, 8, 16};
  int unsigned phase_mode[PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_LOOKUP;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    reqs_accepted = 0;
    replies_seen = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 6; i++) status_tally[i] = 0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_key[i] = '0;
      shadow_handle[i] = '0;
      shadow_live[i] = 1'b0;
      shadow_rank[i] = '0;
    end
    shadow_fill = 0;
    shadow_cap = CAP_RESET;

    // Extreme keys first, the rest random and distinct with high probability.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = random_key();
    last_key = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CAP_BITS'(phase_cap[p]));
      case (phase_mode[p])
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      if (p == 0) begin
        // Directed: miss on empty store, extreme keys and handles, update,
        // fill to capacity, evict the least recent, then look up the victim.
        queue_req(REQ_LOOKUP, key_pool[0], '0);
        queue_req(REQ_ADD, key_pool[0], '0);
        queue_req(REQ_ADD, key_pool[1], '1);
        queue_req(REQ_LOOKUP, key_pool[1], '0);
        queue_req(REQ_ADD, key_pool[0], 32'ha5a5a5a5);
        queue_req(REQ_LOOKUP, key_pool[0], '1);
        for (int i = 2; i < 16; i++) queue_req(REQ_ADD, key_pool[i], $urandom());
        queue_req(REQ_ADD, key_pool[16], 32'h5a5a5a5a);
        queue_req(REQ_LOOKUP, key_pool[1], '0);
        queue_req(REQ_LOOKUP, key_pool[16], '0);
        wait_drained();
      end

      // First half, then a full pause until every reply is back, then the rest.
      for (int n = 0; n < RAND_PER_PHASE / 2; n++) queue_random_req();
      wait_drained();
      for (int n = RAND_PER_PHASE / 2; n < RAND_PER_PHASE; n++) queue_random_req();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (predicted_replies.size() > 0) begin
      report_mismatch($sformatf("predicted %s never arrived",
                                predicted_replies[0].status.name()));
      void'(predicted_replies.pop_front());
    end

    $display("covered %0d requests over capacities 0, 1, 2, 3, 8, 16 and 31", reqs_accepted);
    $display("miss %0d, hit %0d, updated %0d, inserted %0d, evicted %0d, rejected %0d",
             status_tally[STAT_MISS], status_tally[STAT_HIT], status_tally[STAT_UPDATED],
             status_tally[STAT_INSERTED], status_tally[STAT_EVICTED],
             status_tally[STAT_REJECTED]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
